### design/imuts_pkg.sv
`default_nettype none
package imuts_pkg;

  // Default queue depths
  localparam int unsigned IMU_DEPTH_DEF   = 32;
  localparam int unsigned IMAGE_DEPTH_DEF = 8;

  // Field widths
  localparam int unsigned STAMP_W  = 48;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned ENTRY_W  = STAMP_W + HANDLE_W;
  localparam int unsigned DELAY_W  = 21;
  localparam int unsigned TOL_W    = 24;
  localparam int unsigned LIMIT_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  // Signed width for stamp/delay/tolerance arithmetic
  localparam int unsigned CALC_W = STAMP_W + 3;

  // Function codes
  localparam logic [1:0] FUNC_IMU   = 2'd0;
  localparam logic [1:0] FUNC_IMAGE = 2'd1;
  localparam logic [1:0] FUNC_PULL  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_IMAGE    = 3'd0;
  localparam logic [2:0] KIND_IMU      = 3'd1;
  localparam logic [2:0] KIND_NOTREADY = 3'd2;
  localparam logic [2:0] KIND_GAP      = 3'd3;
  localparam logic [2:0] KIND_UNSYNC   = 3'd4;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAPTOL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ULIMIT = 2'd3;

  // Config reset values
  localparam logic [TOL_W-1:0]   GAPTOL_RST = 24'd3000000;
  localparam logic [LIMIT_W-1:0] ULIMIT_RST = 4'd10;

  typedef struct packed {
    logic [1:0]          func;
    logic [STAMP_W-1:0]  stamp;
    logic [HANDLE_W-1:0] handle;
  } in_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [HANDLE_W-1:0] msg_handle;
    logic [STAMP_W-1:0]  msg_stamp;
    logic                last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic       arrive;     // arrival item accepted
    logic       rd_gap;     // read newest image, oldest imu
    logic       rd_wait;    // read oldest image, newest imu
    logic       take_img;   // pop oldest image into pending
    logic       take_imu;   // pop oldest imu into pending, read next
    logic       clear;      // empty both queues
    logic       emit_stat;  // emit a status result
    logic [2:0] stat_kind;
    logic       emit_pend;  // emit the pending entry
    logic       pend_last;
    logic       unsync_bump;
    logic       unsync_zero;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pull_ok;     // normal mode, both queues non-empty
    logic gap_fail;
    logic wait_fail;
    logic imu_empty;
    logic imu_older;   // head imu older than image limit
    logic unsync_over;
    logic pend_img;    // pending entry is the image
  } stat_t;

endpackage
`default_nettype wire

### design/imuts_ctrl.sv
`default_nettype none
module imuts_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [1:0]      func_i,
  input  wire imuts_pkg::stat_t stat_i,
  output imuts_pkg::cmd_t      cmd_o,
  output logic                 busy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GAP,
    S_WAIT,
    S_WALK
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (func_i == imuts_pkg::FUNC_PULL) begin
            if (stat_i.pull_ok) begin
              cmd_o.rd_gap = 1'b1;
              state_d      = S_GAP;
            end else begin
              cmd_o.emit_stat = 1'b1;
              cmd_o.stat_kind = imuts_pkg::KIND_NOTREADY;
            end
          end else begin
            cmd_o.arrive = 1'b1;
          end
        end
      end
      S_GAP: begin
        if (stat_i.gap_fail) begin
          cmd_o.clear     = 1'b1;
          cmd_o.emit_stat = 1'b1;
          cmd_o.stat_kind = imuts_pkg::KIND_GAP;
          state_d         = S_IDLE;
        end else begin
          cmd_o.rd_wait = 1'b1;
          state_d       = S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat_i.wait_fail) begin
          cmd_o.emit_stat = 1'b1;
          cmd_o.stat_kind = imuts_pkg::KIND_NOTREADY;
          state_d         = S_IDLE;
        end else begin
          cmd_o.take_img = 1'b1;
          state_d        = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.imu_empty) begin
          cmd_o.emit_pend = 1'b1;
          cmd_o.pend_last = 1'b1;
          state_d         = S_IDLE;
        end else if (stat_i.imu_older) begin
          cmd_o.emit_pend   = 1'b1;
          cmd_o.take_imu    = 1'b1;
          cmd_o.unsync_zero = 1'b1;
        end else if (stat_i.pend_img && stat_i.unsync_over) begin
          cmd_o.clear       = 1'b1;
          cmd_o.unsync_zero = 1'b1;
          cmd_o.emit_stat   = 1'b1;
          cmd_o.stat_kind   = imuts_pkg::KIND_UNSYNC;
          state_d           = S_IDLE;
        end else begin
          cmd_o.unsync_bump = 1'b1;
          cmd_o.emit_pend   = 1'b1;
          cmd_o.pend_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

### design/imuts_dpath.sv
`default_nettype none
module imuts_dpath #(
  parameter int unsigned IMU_DEPTH   = imuts_pkg::IMU_DEPTH_DEF,
  parameter int unsigned IMAGE_DEPTH = imuts_pkg::IMAGE_DEPTH_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire imuts_pkg::in_t                         item_i,
  input  wire imuts_pkg::cmd_t                        cmd_i,
  input  wire logic                                   cfg_we_i,
  input  wire logic [imuts_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [imuts_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output imuts_pkg::stat_t                            stat_o,
  output logic                                        res_valid_o,
  output imuts_pkg::out_t                             res_o
);

  localparam int unsigned MPW = (IMU_DEPTH > 1) ? $clog2(IMU_DEPTH) : 1;
  localparam int unsigned MFW = $clog2(IMU_DEPTH + 1);
  localparam int unsigned MSW = MFW + 2;
  localparam int unsigned GPW = (IMAGE_DEPTH > 1) ? $clog2(IMAGE_DEPTH) : 1;
  localparam int unsigned GFW = $clog2(IMAGE_DEPTH + 1);
  localparam int unsigned GSW = GFW + 1;
  localparam int unsigned EW  = imuts_pkg::ENTRY_W;
  localparam int unsigned SW  = imuts_pkg::STAMP_W;
  localparam int unsigned HW  = imuts_pkg::HANDLE_W;
  localparam int unsigned CW  = imuts_pkg::CALC_W;
  localparam int unsigned DW  = imuts_pkg::DELAY_W;
  localparam int unsigned TW  = imuts_pkg::TOL_W;
  localparam int unsigned LW  = imuts_pkg::LIMIT_W;

  typedef enum logic [1:0] {
    M_IDLE,
    M_STARTED,
    M_NORMAL
  } mode_e;

  // Config registers
  logic [DW-1:0] delay_q;
  logic          keep2_q;
  logic [TW-1:0] gaptol_q;
  logic [LW-1:0] ulimit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= '0;
      keep2_q  <= 1'b0;
      gaptol_q <= imuts_pkg::GAPTOL_RST;
      ulimit_q <= imuts_pkg::ULIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        imuts_pkg::REG_DELAY:  delay_q  <= cfg_data_i[DW-1:0];
        imuts_pkg::REG_KEEP2:  keep2_q  <= cfg_data_i[0];
        imuts_pkg::REG_GAPTOL: gaptol_q <= cfg_data_i[TW-1:0];
        imuts_pkg::REG_ULIMIT: ulimit_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  mode_e          mode_q, mode_d;
  logic [SW-1:0]  start_q, start_d;
  logic [LW-1:0]  unsync_q, unsync_d;
  logic [MPW-1:0] mhead_q, mhead_d;
  logic [MFW-1:0] mfill_q, mfill_d;
  logic [GPW-1:0] ghead_q, ghead_d;
  logic [GFW-1:0] gfill_q, gfill_d;

  // Payload registers
  logic [EW-1:0]  mrd_q, grd_q, pend_q, pend_d;
  logic           pend_img_q, pend_img_d;
  logic [CW-1:0]  limit_q, limit_d;

  logic [EW-1:0] mmem [IMU_DEPTH];
  logic [EW-1:0] gmem [IMAGE_DEPTH];

  // Signed views
  logic signed [CW-1:0] delay_x, stamp_x, start_x;
  assign delay_x = CW'(signed'(delay_q));
  assign stamp_x = CW'(item_i.stamp);
  assign start_x = CW'(start_q);

  logic signed [CW-1:0] m_plus_d, g_minus_d;
  assign m_plus_d  = stamp_x + delay_x;
  assign g_minus_d = stamp_x - delay_x;

  // Ring addresses
  logic [MSW-1:0] m_tail_s, m_new_s, m_next_s;
  logic [GSW-1:0] g_tail_s, g_new_s;
  logic [MPW-1:0] m_tail, m_new, m_next;
  logic [GPW-1:0] g_tail, g_new, g_next;

  always_comb begin
    m_tail_s = MSW'(mhead_q) + MSW'(mfill_q);
    if (m_tail_s >= MSW'(IMU_DEPTH)) m_tail_s = m_tail_s - MSW'(IMU_DEPTH);
    m_tail = m_tail_s[MPW-1:0];
    m_new_s = MSW'(mhead_q) + MSW'(mfill_q) + MSW'(IMU_DEPTH - 1);
    if (m_new_s >= MSW'(IMU_DEPTH)) m_new_s = m_new_s - MSW'(IMU_DEPTH);
    if (m_new_s >= MSW'(IMU_DEPTH)) m_new_s = m_new_s - MSW'(IMU_DEPTH);
    m_new = m_new_s[MPW-1:0];
    m_next_s = MSW'(mhead_q) + MSW'(1);
    if (m_next_s >= MSW'(IMU_DEPTH)) m_next_s = '0;
    m_next = m_next_s[MPW-1:0];

    g_tail_s = GSW'(ghead_q) + GSW'(gfill_q);
    if (g_tail_s >= GSW'(IMAGE_DEPTH)) g_tail_s = g_tail_s - GSW'(IMAGE_DEPTH);
    g_tail = g_tail_s[GPW-1:0];
    g_new_s = GSW'(ghead_q) + GSW'(gfill_q) + GSW'(IMAGE_DEPTH - 1);
    if (g_new_s >= GSW'(IMAGE_DEPTH)) g_new_s = g_new_s - GSW'(IMAGE_DEPTH);
    if (g_new_s >= GSW'(IMAGE_DEPTH)) g_new_s = g_new_s - GSW'(IMAGE_DEPTH);
    g_new = g_new_s[GPW-1:0];
    g_next = (ghead_q == GPW'(IMAGE_DEPTH - 1)) ? '0 : ghead_q + GPW'(1);
  end

  // Arrival decisions
  logic m_push, g_push, set_start, go_normal;
  logic m_we, g_we;
  logic [GFW-1:0] gfill_a;

  always_comb begin
    m_push    = 1'b0;
    g_push    = 1'b0;
    set_start = 1'b0;
    go_normal = 1'b0;
    if (cmd_i.arrive && item_i.func == imuts_pkg::FUNC_IMU) begin
      if (!delay_q[DW-1]) begin
        m_push    = 1'b1;
        set_start = (mode_q == M_IDLE);
      end else if (mode_q == M_STARTED) begin
        if (m_plus_d > start_x) begin
          m_push    = 1'b1;
          go_normal = 1'b1;
        end
      end else if (mode_q == M_NORMAL) begin
        m_push = 1'b1;
      end
    end
    if (cmd_i.arrive && item_i.func == imuts_pkg::FUNC_IMAGE) begin
      if (!delay_q[DW-1]) begin
        if (mode_q == M_STARTED) begin
          if (g_minus_d > start_x) begin
            g_push    = 1'b1;
            go_normal = 1'b1;
          end
        end else if (mode_q == M_NORMAL) begin
          g_push = 1'b1;
        end
      end else if (mode_q == M_IDLE) begin
        set_start = 1'b1;
      end else begin
        g_push = 1'b1;
      end
    end
  end

  assign m_we = m_push && (mfill_q < MFW'(IMU_DEPTH));
  assign g_we = g_push && (gfill_q < GFW'(IMAGE_DEPTH));

  // State update
  always_comb begin
    mode_d     = mode_q;
    start_d    = start_q;
    unsync_d   = unsync_q;
    mhead_d    = mhead_q;
    mfill_d    = mfill_q;
    ghead_d    = ghead_q;
    gfill_d    = gfill_q;
    pend_d     = pend_q;
    pend_img_d = pend_img_q;
    limit_d    = limit_q;
    gfill_a    = gfill_q + GFW'(g_we);

    if (set_start) begin
      start_d = item_i.stamp;
      mode_d  = M_STARTED;
    end
    if (go_normal) mode_d = M_NORMAL;
    if (m_we) mfill_d = mfill_q + MFW'(1);
    if (cmd_i.arrive && item_i.func == imuts_pkg::FUNC_IMAGE) begin
      // real-time mode keeps only the two newest images
      if (keep2_q && gfill_a > GFW'(2)) begin
        ghead_d = g_next;
        gfill_d = gfill_a - GFW'(1);
      end else begin
        gfill_d = gfill_a;
      end
    end

    if (cmd_i.take_img) begin
      pend_d     = grd_q;
      pend_img_d = 1'b1;
      limit_d    = CW'(grd_q[EW-1:HW]) - delay_x;
      ghead_d    = g_next;
      gfill_d    = gfill_q - GFW'(1);
    end
    if (cmd_i.take_imu) begin
      pend_d     = mrd_q;
      pend_img_d = 1'b0;
      mhead_d    = m_next;
      mfill_d    = mfill_q - MFW'(1);
    end
    if (cmd_i.unsync_zero) unsync_d = '0;
    if (cmd_i.unsync_bump && unsync_q != '1) unsync_d = unsync_q + LW'(1);
    if (cmd_i.clear) begin
      mhead_d = '0;
      mfill_d = '0;
      ghead_d = '0;
      gfill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      start_q  <= '0;
      unsync_q <= '0;
      mhead_q  <= '0;
      mfill_q  <= '0;
      ghead_q  <= '0;
      gfill_q  <= '0;
      pend_img_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      unsync_q <= unsync_d;
      mhead_q  <= mhead_d;
      mfill_q  <= mfill_d;
      ghead_q  <= ghead_d;
      gfill_q  <= gfill_d;
      pend_img_q <= pend_img_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    limit_q <= limit_d;
  end

  // Queue memories, registered reads
  logic [MPW-1:0] m_raddr;
  logic [GPW-1:0] g_raddr;

  always_comb begin
    m_raddr = mhead_q;
    if (cmd_i.rd_wait)  m_raddr = m_new;
    if (cmd_i.take_imu) m_raddr = m_next;
    g_raddr = ghead_q;
    if (cmd_i.rd_gap) g_raddr = g_new;
  end

  always_ff @(posedge clk_i) begin
    if (m_we) mmem[m_tail] <= {item_i.stamp, item_i.handle};
    if (g_we) gmem[g_tail] <= {item_i.stamp, item_i.handle};
    mrd_q <= mmem[m_raddr];
    grd_q <= gmem[g_raddr];
  end

  // Status compares
  logic signed [CW-1:0] g_rd_x, m_rd_x;
  assign g_rd_x = CW'(grd_q[EW-1:HW]);
  assign m_rd_x = CW'(mrd_q[EW-1:HW]);

  always_comb begin
    stat_o.pull_ok     = (mode_q == M_NORMAL) && (mfill_q != '0) && (gfill_q != '0);
    stat_o.gap_fail    = (g_rd_x - delay_x + signed'(CW'(gaptol_q))) < m_rd_x;
    stat_o.wait_fail   = (g_rd_x - delay_x) > m_rd_x;
    stat_o.imu_empty   = (mfill_q == '0);
    stat_o.imu_older   = m_rd_x < signed'(limit_q);
    stat_o.unsync_over = unsync_q > ulimit_q;
    stat_o.pend_img    = pend_img_q;
  end

  // Result register
  logic res_valid_q;
  imuts_pkg::out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_stat || cmd_i.emit_pend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_stat) begin
      res_q.kind       <= cmd_i.stat_kind;
      res_q.msg_handle <= '0;
      res_q.msg_stamp  <= '0;
      res_q.last       <= 1'b1;
    end else if (cmd_i.emit_pend) begin
      res_q.kind       <= pend_img_q ? imuts_pkg::KIND_IMAGE : imuts_pkg::KIND_IMU;
      res_q.msg_handle <= pend_q[HW-1:0];
      res_q.msg_stamp  <= pend_q[EW-1:HW];
      res_q.last       <= cmd_i.pend_last;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

### design/imu_image_timestamp_sync_core.sv
// Arrivals (imu, image): no result, busy stays low.
// Pull, not ready at once: one result in the cycle after the transfer.
// Pull otherwise: a status result, or the image result after the GAP, WAIT and
// WALK states, then one imu result per cycle; busy while in those states.
// Results cannot be stalled. Async active-low reset empties both queues.
`default_nettype none
module imu_image_timestamp_sync_core #(
  parameter int unsigned IMU_DEPTH   = imuts_pkg::IMU_DEPTH_DEF,
  parameter int unsigned IMAGE_DEPTH = imuts_pkg::IMAGE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire imuts_pkg::in_t                   item_i,
  output logic                                  res_valid_o,
  output imuts_pkg::out_t                       res_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [imuts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [imuts_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  imuts_pkg::cmd_t  cmd;
  imuts_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  imuts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start && !busy),
    .func_i (item_i.func),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  imuts_dpath #(
    .IMU_DEPTH  (IMU_DEPTH),
    .IMAGE_DEPTH(IMAGE_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .stat_o     (stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule
`default_nettype wire
